@@ rtl/core/es2cal_pkg.sv @@
// Shared constants and helpers for the epoch-seconds to calendar converter.
// Holds the reciprocal multipliers for the constant divisions and the month start table.
// No dependencies.
`default_nettype none

package es2cal_pkg;

    // Field widths of the item channels.
    localparam int EpochW = 32;
    localparam int SecW   = 6;
    localparam int MinW   = 6;
    localparam int HourW  = 5;
    localparam int DayW   = 5;
    localparam int MonW   = 4;
    localparam int YearW  = 12;

    // Calendar constants.
    localparam int HoursPerDay  = 24;
    localparam int DaysPerYear  = 365;
    localparam int DaysPerCycle = 1461;
    localparam int BaseYear     = 1970;
    localparam int HoursPerYear = DaysPerYear * HoursPerDay;
    localparam int HoursPerLeap = (DaysPerYear + 1) * HoursPerDay;
    localparam int HoursPerCyc  = DaysPerCycle * HoursPerDay;

    // Zero-based day of a leap year that is 29 February.
    localparam int LeapDayOrd0  = 59;

    // Divide by 60 as a shift by 2 and a reciprocal multiply for 15.
    // Seconds: 30-bit dividend, shift 34. Minutes: 25-bit dividend, shift 29.
    localparam logic [30:0] RecipSec = 31'd1145324613;
    localparam int          ShiftSec = 34;
    localparam logic [25:0] RecipMin = 26'd35791395;
    localparam int          ShiftMin = 29;

    // Divide hours by 35064 as a shift by 3 and a reciprocal multiply for 4383.
    localparam logic [18:0] RecipCyc = 19'd489958;
    localparam int          ShiftCyc = 31;

    // Divide hours of a year by 24 as a shift by 3 and a reciprocal multiply for 3.
    localparam logic [11:0] RecipDay = 12'd2731;
    localparam int          ShiftDay = 13;

    typedef logic [8:0] t_yday;
    typedef logic [3:0] t_mon;

    // Zero-based day of a non-leap year on which a month begins.
    function automatic t_yday month_start(input t_mon mon);
        t_yday s;
        unique case (mon)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/epoch_seconds_to_calendar_top.sv @@
// Epoch-seconds to calendar converter: one timestamp in, one broken-down date out per item.
// One item is accepted every cycle while the output is not stalled.
// While a result waits at a stalled output, all eight stages freeze together; otherwise they
// all advance. Depends on es2cal_pkg.
// Every year with two low bits zero counts as leap, so dates are exact through 2099.
`default_nettype none

module epoch_seconds_to_calendar_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_second,
    output logic [5:0]       o_minute,
    output logic [4:0]       o_hour,
    output logic [4:0]       o_day_of_month,
    output logic [3:0]       o_month_index,
    output logic [11:0]      o_year
);

    // Pipeline control: all stages move together unless a held result blocks them.
    logic       w_adv;
    logic [7:0] r_vld;

    assign w_adv   = !i_stall || !r_vld[7];
    assign o_stall = !w_adv;
    assign o_valid = r_vld[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // Stage A: reciprocal multiply for the division by 60 of the seconds count.
    logic [60:0] r_a_prod;
    logic [7:0]  r_a_lo;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_prod <= {31'd0, i_epoch_seconds[31:2]} * {30'd0, es2cal_pkg::RecipSec};
            r_a_lo   <= i_epoch_seconds[7:0];
        end
    end

    // Stage B: seconds remainder and the reciprocal multiply for the minutes.
    logic [26:0] w_b_mins;
    logic [7:0]  w_b_x60;
    logic [7:0]  w_b_sec;
    logic [5:0]  r_b_sec;
    logic [7:0]  r_b_lo;
    logic [50:0] r_b_prod;

    assign w_b_mins = r_a_prod[es2cal_pkg::ShiftSec +: 27];
    assign w_b_x60  = (w_b_mins[7:0] << 6) - (w_b_mins[7:0] << 2);
    assign w_b_sec  = r_a_lo - w_b_x60;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_sec  <= w_b_sec[5:0];
            r_b_lo   <= w_b_mins[7:0];
            r_b_prod <= {26'd0, w_b_mins[26:2]} * {25'd0, es2cal_pkg::RecipMin};
        end
    end

    // Stage C: minutes remainder and the reciprocal multiply for whole four-year cycles.
    logic [20:0] w_c_hours;
    logic [7:0]  w_c_x60;
    logic [7:0]  w_c_min;
    logic [5:0]  r_c_sec;
    logic [5:0]  r_c_min;
    logic [20:0] r_c_hours;
    logic [36:0] r_c_prod;

    assign w_c_hours = r_b_prod[es2cal_pkg::ShiftMin +: 21];
    assign w_c_x60   = (w_c_hours[7:0] << 6) - (w_c_hours[7:0] << 2);
    assign w_c_min   = r_b_lo - w_c_x60;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_sec   <= r_b_sec;
            r_c_min   <= w_c_min[5:0];
            r_c_hours <= w_c_hours;
            r_c_prod  <= {19'd0, w_c_hours[20:3]} * {18'd0, es2cal_pkg::RecipCyc};
        end
    end

    // Stage D: hours left within the cycle and the first year of the cycle.
    logic [5:0]  w_d_cyc;
    logic [20:0] w_d_cyc_hours;
    logic [20:0] w_d_rem;
    logic [5:0]  r_d_sec;
    logic [5:0]  r_d_min;
    logic [15:0] r_d_rem;
    logic [11:0] r_d_year;

    assign w_d_cyc       = r_c_prod[es2cal_pkg::ShiftCyc +: 6];
    assign w_d_cyc_hours = 21'(w_d_cyc) * 21'(es2cal_pkg::HoursPerCyc);
    assign w_d_rem       = r_c_hours - w_d_cyc_hours;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_sec  <= r_c_sec;
            r_d_min  <= r_c_min;
            r_d_rem  <= w_d_rem[15:0];
            r_d_year <= 12'(es2cal_pkg::BaseYear) + {4'd0, w_d_cyc, 2'b00};
        end
    end

    // Stage E: step off up to three single years; the cycle starts two years after a leap year.
    logic [1:0]  w_e_yoff;
    logic [15:0] w_e_base;
    logic [15:0] w_e_hiy;
    logic [5:0]  r_e_sec;
    logic [5:0]  r_e_min;
    logic [13:0] r_e_hiy;
    logic        r_e_leap;
    logic [11:0] r_e_year;

    localparam logic [15:0] Thr1 = 16'(es2cal_pkg::HoursPerYear);
    localparam logic [15:0] Thr2 = 16'(2 * es2cal_pkg::HoursPerYear);
    localparam logic [15:0] Thr3 = 16'(2 * es2cal_pkg::HoursPerYear
                                       + es2cal_pkg::HoursPerLeap);

    always_comb begin
        priority if (r_d_rem >= Thr3) begin
            w_e_yoff = 2'd3;
            w_e_base = Thr3;
        end else if (r_d_rem >= Thr2) begin
            w_e_yoff = 2'd2;
            w_e_base = Thr2;
        end else if (r_d_rem >= Thr1) begin
            w_e_yoff = 2'd1;
            w_e_base = Thr1;
        end else begin
            w_e_yoff = 2'd0;
            w_e_base = 16'd0;
        end
    end

    assign w_e_hiy = r_d_rem - w_e_base;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_sec  <= r_d_sec;
            r_e_min  <= r_d_min;
            r_e_hiy  <= w_e_hiy[13:0];
            r_e_leap <= (w_e_yoff == 2'd2);
            r_e_year <= r_d_year + {10'd0, w_e_yoff};
        end
    end

    // Stage F: reciprocal multiply for the division by 24 of the hours within the year.
    logic [5:0]  r_f_sec;
    logic [5:0]  r_f_min;
    logic [4:0]  r_f_hlo;
    logic        r_f_leap;
    logic [11:0] r_f_year;
    logic [22:0] r_f_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_sec  <= r_e_sec;
            r_f_min  <= r_e_min;
            r_f_hlo  <= r_e_hiy[4:0];
            r_f_leap <= r_e_leap;
            r_f_year <= r_e_year;
            r_f_prod <= {12'd0, r_e_hiy[13:3]} * {11'd0, es2cal_pkg::RecipDay};
        end
    end

    // Stage G: hour of day, and the day of year folded onto a non-leap year.
    es2cal_pkg::t_yday w_g_day;
    logic [4:0]        w_g_x24;
    logic              w_g_feb29;
    logic [5:0]        r_g_sec;
    logic [5:0]        r_g_min;
    logic [4:0]        r_g_hour;
    logic              r_g_feb29;
    logic [11:0]       r_g_year;
    es2cal_pkg::t_yday r_g_day;

    assign w_g_day   = r_f_prod[es2cal_pkg::ShiftDay +: 9];
    assign w_g_x24   = {w_g_day[0], 4'b0000} + {w_g_day[1:0], 3'b000};
    assign w_g_feb29 = r_f_leap && (w_g_day == 9'(es2cal_pkg::LeapDayOrd0));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_sec   <= r_f_sec;
            r_g_min   <= r_f_min;
            r_g_hour  <= r_f_hlo - w_g_x24;
            r_g_feb29 <= w_g_feb29;
            r_g_year  <= r_f_year;
            if (r_f_leap && (w_g_day > 9'(es2cal_pkg::LeapDayOrd0))) begin
                r_g_day <= w_g_day - 9'd1;
            end else begin
                r_g_day <= w_g_day;
            end
        end
    end

    // Stage H: month lookup against the month start table, with 29 February apart.
    es2cal_pkg::t_mon  w_h_mon;
    es2cal_pkg::t_yday w_h_dom;

    always_comb begin
        w_h_mon = '0;
        for (int k = 1; k < 12; k++) begin
            if (r_g_day >= es2cal_pkg::month_start(4'(k))) begin
                w_h_mon = 4'(k);
            end
        end
    end

    assign w_h_dom = r_g_day - es2cal_pkg::month_start(w_h_mon) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_second <= r_g_sec;
            o_minute <= r_g_min;
            o_hour   <= r_g_hour;
            o_year   <= r_g_year;
            if (r_g_feb29) begin
                o_month_index  <= 4'd1;
                o_day_of_month <= 5'd29;
            end else begin
                o_month_index  <= w_h_mon;
                o_day_of_month <= w_h_dom[4:0];
            end
        end
    end

endmodule

`default_nettype wire
